// File: rtl/cbe_pkg.sv
// Package for the cubic Bezier extremum block: defaults, constants, back-end states.
// No dependencies; imported by the top level, the front end and the back end.
`default_nettype none
package cbe_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int TOL_WIDTH       = 16;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;
    localparam int DZ_LIMIT_BITS   = 32;
    localparam int DZ_SCALE        = 36;
    localparam int TOL_SHIFT       = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int OUT_DEPTH       = 4;
    localparam int PADDR_WIDTH     = 3;
    localparam int PDATA_WIDTH     = 32;
    localparam logic REG_TOL       = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ONE, ST_AXIS, ST_MUL, ST_CLASS, ST_SQRT,
        ST_DIVSET, ST_DIV, ST_EMIT, ST_NEXT, ST_LAST
    } t_state;
endpackage
`default_nettype wire

// File: rtl/cubic_bezier_extrema_top.sv
// The back end works serially: multiplier, square root and divider, one bit per cycle;
// an axis with near-zero lead coefficient skips the multiplier and square root.
// Throughput is one curve per back-end pass; two coefficient sets wait in the queue
// while it works.
// Reset (synchronous, active low) empties all queues, idles the solver, tolerance = 1.
`default_nettype none
module cubic_bezier_extrema_top #(
    parameter int COORD_WIDTH = cbe_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = cbe_pkg::T_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [cbe_pkg::PADDR_WIDTH-1:0]     paddr,
    input  wire logic [cbe_pkg::PDATA_WIDTH-1:0]     pwdata,
    output logic [cbe_pkg::PDATA_WIDTH-1:0]          prdata,
    output logic                                     pready,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [COORD_WIDTH-1:0]       i_p0_x,
    input  wire logic signed [COORD_WIDTH-1:0]       i_p0_y,
    input  wire logic signed [COORD_WIDTH-1:0]       i_p1_x,
    input  wire logic signed [COORD_WIDTH-1:0]       i_p1_y,
    input  wire logic signed [COORD_WIDTH-1:0]       i_p2_x,
    input  wire logic signed [COORD_WIDTH-1:0]       i_p2_y,
    input  wire logic signed [COORD_WIDTH-1:0]       i_p3_x,
    input  wire logic signed [COORD_WIDTH-1:0]       i_p3_y,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [T_FRAC_BITS:0]                     o_param_t,
    output logic                                     o_last
);
    import cbe_pkg::*;

    localparam int AXW = 3 * (COORD_WIDTH + 3) + 2;
    localparam int OW  = T_FRAC_BITS + 2;

    logic [TOL_WIDTH-1:0] r_tol;
    logic                 q_push, q_full, q_pop, q_empty;
    logic [2*AXW-1:0]     q_in, q_out;
    logic                 out_push, out_full;
    logic [OW-1:0]        out_in, out_head;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOL) ? PDATA_WIDTH'(r_tol) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_TOL) begin
            r_tol <= pwdata[TOL_WIDTH-1:0];
        end
    end

    cbe_front #(.CW(COORD_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tol    (r_tol),
        .i_push   (push),
        .o_full   (full),
        .i_p0_x   (i_p0_x),
        .i_p0_y   (i_p0_y),
        .i_p1_x   (i_p1_x),
        .i_p1_y   (i_p1_y),
        .i_p2_x   (i_p2_x),
        .i_p2_y   (i_p2_y),
        .i_p3_x   (i_p3_x),
        .i_p3_y   (i_p3_y),
        .o_q_push (q_push),
        .o_q_data (q_in),
        .i_q_full (q_full)
    );

    cbe_fifo #(.W(2*AXW), .DEPTH(QUEUE_DEPTH)) u_coef_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    cbe_back #(.CW(COORD_WIDTH), .TF(T_FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tol      (r_tol),
        .i_q_empty  (q_empty),
        .i_q_data   (q_out),
        .o_q_pop    (q_pop),
        .o_out_push (out_push),
        .o_out_data (out_in),
        .i_out_full (out_full)
    );

    cbe_fifo #(.W(OW), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_head),
        .o_empty (empty)
    );

    assign o_param_t = out_head[OW-1:1];
    assign o_last    = out_head[0];
endmodule
`default_nettype wire

// File: rtl/cbe_fifo.sv
// Small register queue, first-word fall-through.
// Depends on nothing but its parameters.
`default_nettype none
module cbe_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr, rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(wr) - CW'(rd);
        end
    end
endmodule
`default_nettype wire

// File: rtl/cbe_front.sv
// Front end: takes a curve beat, forms derivative coefficients per axis and
// flags near-zero ones. Depends on cbe_pkg.
`default_nettype none
module cbe_front #(
    parameter int CW = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [cbe_pkg::TOL_WIDTH-1:0]   i_tol,
    input  wire logic                            i_push,
    output logic                                 o_full,
    input  wire logic signed [CW-1:0]            i_p0_x,
    input  wire logic signed [CW-1:0]            i_p0_y,
    input  wire logic signed [CW-1:0]            i_p1_x,
    input  wire logic signed [CW-1:0]            i_p1_y,
    input  wire logic signed [CW-1:0]            i_p2_x,
    input  wire logic signed [CW-1:0]            i_p2_y,
    input  wire logic signed [CW-1:0]            i_p3_x,
    input  wire logic signed [CW-1:0]            i_p3_y,
    output logic                                 o_q_push,
    output logic [2*(3*(CW+3)+2)-1:0]            o_q_data,
    input  wire logic                            i_q_full
);
    import cbe_pkg::*;

    localparam int KW  = CW + 3;
    localparam int LW  = KW + 3;
    localparam int AXW = 3 * KW + 2;

    logic signed [CW-1:0] r_p [8];
    logic                 r_vld;
    logic                 acc;
    logic [AXW-1:0]       ax_x, ax_y;

    function automatic logic near_zero(input logic signed [LW-1:0] v,
                                       input logic [TOL_WIDTH-1:0] tol);
        logic [LW-1:0] m;
        m = v[LW-1] ? LW'(-v) : LW'(v);
        return (m == '0) || (m < LW'(tol));
    endfunction

    function automatic logic [AXW-1:0] classify(input logic signed [CW-1:0] p0,
                                                input logic signed [CW-1:0] p1,
                                                input logic signed [CW-1:0] p2,
                                                input logic signed [CW-1:0] p3,
                                                input logic [TOL_WIDTH-1:0] tol);
        logic signed [KW-1:0] e0, e1, e2, e3, a, b, c;
        logic signed [LW-1:0] a3, b6;
        e0 = KW'(p0);
        e1 = KW'(p1);
        e2 = KW'(p2);
        e3 = KW'(p3);
        a  = e3 - e0 + e1 + (e1 <<< 1) - e2 - (e2 <<< 1);
        b  = e0 - (e1 <<< 1) + e2;
        c  = e1 - e0;
        a3 = LW'(a) + (LW'(a) <<< 1);
        b6 = (LW'(b) <<< 1) + (LW'(b) <<< 2);
        return {near_zero(a3, tol), near_zero(b6, tol), a, b, c};
    endfunction

    assign o_full   = r_vld && i_q_full;
    assign acc      = i_push && !o_full;
    assign o_q_push = r_vld && !i_q_full;
    assign ax_x     = classify(r_p[0], r_p[2], r_p[4], r_p[6], i_tol);
    assign ax_y     = classify(r_p[1], r_p[3], r_p[5], r_p[7], i_tol);
    assign o_q_data = {ax_y, ax_x};

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p[0] <= i_p0_x;
            r_p[1] <= i_p0_y;
            r_p[2] <= i_p1_x;
            r_p[3] <= i_p1_y;
            r_p[4] <= i_p2_x;
            r_p[5] <= i_p2_y;
            r_p[6] <= i_p3_x;
            r_p[7] <= i_p3_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (acc) begin
            r_vld <= 1'b1;
        end else if (o_q_push) begin
            r_vld <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// File: rtl/cbe_back.sv
// Back end: per-axis root solver with serial multiplier, square root and divider.
// Depends on cbe_pkg; emits parameter beats with the last flag.
`default_nettype none
module cbe_back #(
    parameter int CW = 32,
    parameter int TF = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [cbe_pkg::TOL_WIDTH-1:0]   i_tol,
    input  wire logic                            i_q_empty,
    input  wire logic [2*(3*(CW+3)+2)-1:0]       i_q_data,
    output logic                                 o_q_pop,
    output logic                                 o_out_push,
    output logic [TF+1:0]                        o_out_data,
    input  wire logic                            i_out_full
);
    import cbe_pkg::*;

    localparam int KW    = CW + 3;
    localparam int AXW   = 3 * KW + 2;
    localparam int DW    = 2 * CW + 4;
    localparam int SW    = CW + 2;
    localparam int RW    = SW + 3;
    localparam int NW    = CW + 4;
    localparam int MAXIT = (KW > TF) ? KW : TF;
    localparam int CNTW  = $clog2(MAXIT + 1);
    localparam int DZW   = DZ_LIMIT_BITS + 6;

    t_state                r_state, n_state;
    logic [2*AXW-1:0]      r_coef, n_coef;
    logic                  r_axis, n_axis;
    logic                  r_phase, n_phase;
    logic [DW-1:0]         r_mcand, n_mcand;
    logic [KW-1:0]         r_mplier, n_mplier;
    logic [DW-1:0]         r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic signed [DW-1:0]  r_d, n_d;
    logic [DW-1:0]         r_src, n_src;
    logic [RW-1:0]         r_rem, n_rem;
    logic [SW-1:0]         r_root, n_root;
    logic signed [NW-1:0]  r_num, n_num, r_den, n_den;
    logic [NW:0]           r_dr, n_dr;
    logic [NW-1:0]         r_dd, n_dd;
    logic [TF-1:0]         r_q, n_q;
    logic                  r_more, n_more;
    logic [TF:0]           r_pend, n_pend;
    logic [CNTW-1:0]       r_cnt, n_cnt;

    logic [AXW-1:0]        cur;
    logic signed [KW-1:0]  ca, cb, cc;
    logic                  a_nz, b_nz, last_it;
    logic [DW-1:0]         acc_new, dm;
    logic                  dzero;
    logic [DZW-1:0]        dz_prod;
    logic [RW-1:0]         rem_sh, trial;
    logic [SW-1:0]         root_new;
    logic [RW-1:0]         rem_new;
    logic signed [NW-1:0]  nn, dd, neg_b;
    logic                  div_skip;
    logic [NW:0]           dsh;
    logic [TF-1:0]         q_new;
    logic [NW:0]           dr_new;

    function automatic logic [KW-1:0] mag_k(input logic signed [KW-1:0] v);
        return v[KW-1] ? KW'(-v) : KW'(v);
    endfunction

    assign cur     = r_axis ? r_coef[2*AXW-1:AXW] : r_coef[AXW-1:0];
    assign cc      = cur[KW-1:0];
    assign cb      = cur[2*KW-1:KW];
    assign ca      = cur[3*KW-1:2*KW];
    assign b_nz    = cur[3*KW];
    assign a_nz    = cur[3*KW+1];
    assign last_it = (r_cnt == CNTW'(1));
    assign neg_b   = -NW'(cb);

    assign acc_new = r_acc + (r_mplier[0] ? r_mcand : '0);

    assign dm      = r_d[DW-1] ? DW'(-r_d) : DW'(r_d);
    assign dz_prod = DZW'(dm[DZ_LIMIT_BITS-1:0]) * DZW'(DZ_SCALE);
    assign dzero   = (dm == '0) ||
                     ((dm >> DZ_LIMIT_BITS) == '0 &&
                      dz_prod < (DZW'(i_tol) << TOL_SHIFT));

    assign rem_sh  = {r_rem[RW-3:0], r_src[DW-1:DW-2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign root_new = (rem_sh >= trial) ? {r_root[SW-2:0], 1'b1} : {r_root[SW-2:0], 1'b0};
    assign rem_new  = (rem_sh >= trial) ? rem_sh - trial : rem_sh;

    assign nn       = r_den[NW-1] ? -r_num : r_num;
    assign dd       = r_den[NW-1] ? -r_den : r_den;
    assign div_skip = (r_den == '0) || (nn <= 0) || (nn >= dd);

    assign dsh      = {r_dr[NW-1:0], 1'b0};
    assign dr_new   = (dsh >= (NW+1)'(r_dd)) ? dsh - (NW+1)'(r_dd) : dsh;
    assign q_new    = {r_q[TF-2:0], (dsh >= (NW+1)'(r_dd))};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (!i_q_empty) n_state = ST_ONE;
            ST_ONE:    if (!i_out_full) n_state = ST_AXIS;
            ST_AXIS: begin
                if (a_nz) begin
                    n_state = b_nz ? ST_NEXT : ST_DIVSET;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:    if (last_it && r_phase) n_state = ST_CLASS;
            ST_CLASS: begin
                if (dzero) begin
                    n_state = ST_DIVSET;
                end else if (r_d[DW-1]) begin
                    n_state = ST_NEXT;
                end else begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT:   if (last_it) n_state = ST_DIVSET;
            ST_DIVSET: begin
                if (!div_skip) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = r_more ? ST_DIVSET : ST_NEXT;
                end
            end
            ST_DIV:    if (last_it) n_state = ST_EMIT;
            ST_EMIT: begin
                if (r_q == '0 || !i_out_full) begin
                    n_state = r_more ? ST_DIVSET : ST_NEXT;
                end
            end
            ST_NEXT:   n_state = r_axis ? ST_LAST : ST_AXIS;
            ST_LAST:   if (!i_out_full) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_coef     = r_coef;
        n_axis     = r_axis;
        n_phase    = r_phase;
        n_mcand    = r_mcand;
        n_mplier   = r_mplier;
        n_acc      = r_acc;
        n_neg      = r_neg;
        n_d        = r_d;
        n_src      = r_src;
        n_rem      = r_rem;
        n_root     = r_root;
        n_num      = r_num;
        n_den      = r_den;
        n_dr       = r_dr;
        n_dd       = r_dd;
        n_q        = r_q;
        n_more     = r_more;
        n_pend     = r_pend;
        n_cnt      = r_cnt;
        o_q_pop    = 1'b0;
        o_out_push = 1'b0;
        o_out_data = {r_pend, 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_coef  = i_q_data;
                    n_axis  = 1'b0;
                    n_pend  = '0;
                end
            end
            ST_ONE: begin
                if (!i_out_full) begin
                    o_out_push = 1'b1;
                    n_pend     = (TF+1)'(1) << TF;
                end
            end
            ST_AXIS: begin
                if (a_nz) begin
                    n_num  = -NW'(cc);
                    n_den  = NW'(cb) <<< 1;
                    n_more = 1'b0;
                end else begin
                    n_phase  = 1'b0;
                    n_mcand  = DW'(mag_k(cb));
                    n_mplier = mag_k(cb);
                    n_acc    = '0;
                    n_cnt    = CNTW'(KW);
                end
            end
            ST_MUL: begin
                n_acc    = acc_new;
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - 1'b1;
                if (last_it) begin
                    if (!r_phase) begin
                        n_d      = acc_new;
                        n_phase  = 1'b1;
                        n_mcand  = DW'(mag_k(ca));
                        n_mplier = mag_k(cc);
                        n_neg    = ca[KW-1] ^ cc[KW-1];
                        n_acc    = '0;
                        n_cnt    = CNTW'(KW);
                    end else begin
                        n_d = r_neg ? r_d + acc_new : r_d - acc_new;
                    end
                end
            end
            ST_CLASS: begin
                n_num  = neg_b;
                n_den  = NW'(ca);
                n_more = 1'b0;
                n_src  = r_d;
                n_rem  = '0;
                n_root = '0;
                n_cnt  = CNTW'(SW);
            end
            ST_SQRT: begin
                n_src  = r_src << 2;
                n_rem  = rem_new;
                n_root = root_new;
                n_cnt  = r_cnt - 1'b1;
                if (last_it) begin
                    n_num  = neg_b + NW'(root_new);
                    n_den  = NW'(ca);
                    n_more = 1'b1;
                end
            end
            ST_DIVSET: begin
                if (!div_skip) begin
                    n_dr  = (NW+1)'(nn);
                    n_dd  = NW'(dd);
                    n_q   = '0;
                    n_cnt = CNTW'(TF);
                end else if (r_more) begin
                    n_more = 1'b0;
                    n_num  = neg_b - NW'(r_root);
                end
            end
            ST_DIV: begin
                n_dr  = dr_new;
                n_q   = q_new;
                n_cnt = r_cnt - 1'b1;
            end
            ST_EMIT: begin
                if (r_q == '0 || !i_out_full) begin
                    if (r_q != '0) begin
                        o_out_push = 1'b1;
                        n_pend     = {1'b0, r_q};
                    end
                    if (r_more) begin
                        n_more = 1'b0;
                        n_num  = neg_b - NW'(r_root);
                    end
                end
            end
            ST_NEXT: begin
                n_axis = 1'b1;
            end
            ST_LAST: begin
                o_out_data = {r_pend, 1'b1};
                o_out_push = !i_out_full;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef   <= n_coef;
        r_axis   <= n_axis;
        r_phase  <= n_phase;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
        r_neg    <= n_neg;
        r_d      <= n_d;
        r_src    <= n_src;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_num    <= n_num;
        r_den    <= n_den;
        r_dr     <= n_dr;
        r_dd     <= n_dd;
        r_q      <= n_q;
        r_more   <= n_more;
        r_pend   <= n_pend;
        r_cnt    <= n_cnt;
    end
endmodule
`default_nettype wire

// File: rtl/cbe_checker.sv
// Port-level checks on the result channel of cubic_bezier_extrema_top.
// Depends on cbe_pkg; attached to the top level by the bind below.
`default_nettype none
module cbe_checker #(
    parameter int TF = cbe_pkg::T_FRAC_BITS_DEF
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          empty,
    input wire logic          pop,
    input wire logic [TF:0]   o_param_t,
    input wire logic          o_last
);
    logic r_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (pop && !empty) begin
            r_first <= o_last;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_param_t) && $stable(o_last))
        else $error("result beat changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_param_t <= ((TF+1)'(1) << TF))
        else $error("parameter above one");

    a_zero_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_param_t == '0 |-> !o_last)
        else $error("start beat flagged last");

    a_curve_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && r_first |-> o_param_t == '0)
        else $error("curve does not open with zero");
endmodule

bind cubic_bezier_extrema_top cbe_checker #(.TF(T_FRAC_BITS)) u_cbe_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .empty     (empty),
    .pop       (pop),
    .o_param_t (o_param_t),
    .o_last    (o_last)
);
`default_nettype wire
